>>> rtl/cte_pkg.sv
// ----------------------------------------------------------------------------
// Commitment table engine package
// Shared types, codes and default sizes for the commitment table engine.
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_NODE_COUNT  = 32;
    localparam int DEF_TYPE_COUNT  = 4;

    localparam logic [4:0] LIMIT_RESET = 5'd4;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_FULFIL  = 3'd1,
        OP_RELEASE = 3'd2,
        OP_VIOLATE = 3'd3,
        OP_QUERY   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_EMPTY     = 3'd0,
        ST_ACTIVE    = 3'd1,
        ST_FULFILLED = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_VIOLATED  = 3'd4
    } t_entry_st;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_NO_NODE = 2'd1,
        RES_ERROR   = 2'd2
    } t_res_st;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] node_id;
        logic [2:0] vow_type;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_index;
        logic        can_promise;
        logic [4:0]  active_count;
        logic [31:0] fulfilled_total;
        logic [31:0] released_total;
        logic [31:0] violated_total;
    } t_result;

    typedef struct packed {
        logic [7:0] node;
        logic [2:0] kind;
        logic [2:0] status;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;
    } t_ctrl_stat;

endpackage

>>> rtl/cte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cte_ctrl.sv
// ----------------------------------------------------------------------------
// Commitment table engine controller
// Sequences the table scan, the drain of the last read and the commit step.
// ----------------------------------------------------------------------------
module cte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cte_pkg::t_ctrl_stat i_stat,
    output cte_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_busy
);
    import cte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_drain_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_COMMIT))
        else $error("Drain did not lead to commit.");

    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SCAN))
        else $error("Accepted item did not start a scan.");

endmodule

>>> rtl/cte_datapath.sv
// ----------------------------------------------------------------------------
// Commitment table engine datapath
// Holds the table, scans it one entry a cycle and applies the operation.
// ----------------------------------------------------------------------------
module cte_datapath #(
    parameter int TABLE_DEPTH = cte_pkg::DEF_TABLE_DEPTH,
    parameter int NODE_COUNT  = cte_pkg::DEF_NODE_COUNT,
    parameter int TYPE_COUNT  = cte_pkg::DEF_TYPE_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cte_pkg::t_ctrl_cmd  i_cmd,
    output cte_pkg::t_ctrl_stat o_stat,
    input  cte_pkg::t_cmd       i_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output logic                o_strobe,
    output cte_pkg::t_result    o_result
);
    import cte_pkg::*;

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    t_cmd                   r_item;
    logic [4:0]             r_limit;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IW-1:0]          r_addr;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_idx;
    logic                   r_rd_live;
    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_has_empty;
    logic [IW-1:0]          r_empty_idx;
    logic                   r_has_term;
    logic [IW-1:0]          r_term_idx;
    logic [CW-1:0]          r_node_cnt;
    logic [CW-1:0]          r_active;
    logic [31:0]            r_fulf;
    logic [31:0]            r_rel;
    logic [31:0]            r_viol;
    logic                   r_strobe;
    t_result                r_result;

    logic [CW-1:0]          n_active;
    logic [31:0]            n_fulf;
    logic [31:0]            n_rel;
    logic [31:0]            n_viol;
    t_result                n_result;

    t_entry                 rd_entry;
    logic [2:0]             rd_status;
    logic                   node_match;
    logic                   key_match;
    logic                   node_ok;
    logic                   kind_ok;
    logic                   ram_we;
    logic [IW-1:0]          wr_idx;
    t_entry                 wr_entry;
    logic [IW+3:0]          slot_ext;
    logic [CW+4:0]          act_ext;

    cte_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    assign o_stat.scan_last = (r_addr == IW'(TABLE_DEPTH - 1));

    assign rd_status  = r_rd_live ? rd_entry.status : ST_EMPTY;
    assign node_match = (rd_entry.node == r_item.node_id);
    assign key_match  = node_match && (rd_entry.kind == r_item.vow_type);
    assign node_ok    = ({1'b0, r_item.node_id} < 9'(NODE_COUNT));
    assign kind_ok    = ({1'b0, r_item.vow_type} < 4'(TYPE_COUNT));

    always_comb begin
        n_active = r_active;
        n_fulf   = r_fulf;
        n_rel    = r_rel;
        n_viol   = r_viol;
        ram_we   = 1'b0;
        wr_idx   = r_hit_idx;
        wr_entry = '{node: r_item.node_id, kind: r_item.vow_type, status: ST_ACTIVE};
        n_result = '0;
        n_result.status = RES_ERROR;
        unique case (r_item.operation)
            OP_OPEN: begin
                if (!node_ok) begin
                    n_result.status = RES_NO_NODE;
                end else if (kind_ok && !r_hit && (r_has_empty || r_has_term)) begin
                    wr_idx          = r_has_empty ? r_empty_idx : r_term_idx;
                    ram_we          = i_cmd.commit;
                    n_active        = r_active + CW'(1);
                    n_result.status = RES_OK;
                end
            end
            OP_FULFIL, OP_RELEASE, OP_VIOLATE: begin
                if (node_ok && kind_ok && r_hit) begin
                    ram_we          = i_cmd.commit;
                    n_active        = r_active - CW'(1);
                    n_result.status = RES_OK;
                    unique case (r_item.operation)
                        OP_FULFIL: begin
                            wr_entry.status = ST_FULFILLED;
                            n_fulf          = r_fulf + 32'd1;
                        end
                        OP_RELEASE: begin
                            wr_entry.status = ST_RELEASED;
                            n_rel           = r_rel + 32'd1;
                        end
                        default: begin
                            wr_entry.status = ST_VIOLATED;
                            n_viol          = r_viol + 32'd1;
                        end
                    endcase
                end
            end
            OP_QUERY: begin
                n_result.status      = RES_OK;
                n_result.can_promise = node_ok && (CMPW'(r_node_cnt) < CMPW'(r_limit));
            end
            default: begin
                n_result.status = RES_ERROR;
            end
        endcase
        slot_ext = {4'b0, wr_idx};
        act_ext  = {5'b0, n_active};
        if (ram_we) begin
            n_result.slot_index = slot_ext[3:0];
        end
        n_result.active_count    = act_ext[4:0];
        n_result.fulfilled_total = n_fulf;
        n_result.released_total  = n_rel;
        n_result.violated_total  = n_viol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_valid     <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_has_empty <= 1'b0;
            r_has_term  <= 1'b0;
            r_node_cnt  <= '0;
            r_active    <= '0;
            r_fulf      <= '0;
            r_rel       <= '0;
            r_viol      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.scan;
            r_strobe <= i_cmd.commit;
            if (i_cmd.load) begin
                r_addr      <= '0;
                r_hit       <= 1'b0;
                r_has_empty <= 1'b0;
                r_has_term  <= 1'b0;
                r_node_cnt  <= '0;
            end
            if (i_cmd.scan) begin
                r_addr <= r_addr + IW'(1);
            end
            if (r_rd_vld) begin
                if ((rd_status == ST_ACTIVE) && key_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if ((rd_status == ST_EMPTY) && !r_has_empty) begin
                    r_has_empty <= 1'b1;
                end
                if (((rd_status == ST_FULFILLED) || (rd_status == ST_RELEASED) ||
                     (rd_status == ST_VIOLATED)) && !r_has_term) begin
                    r_has_term <= 1'b1;
                end
                if ((rd_status == ST_ACTIVE) && node_match) begin
                    r_node_cnt <= r_node_cnt + CW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_active <= n_active;
                r_fulf   <= n_fulf;
                r_rel    <= n_rel;
                r_viol   <= n_viol;
            end
            if (ram_we) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        r_rd_idx  <= r_addr;
        r_rd_live <= r_valid[r_addr];
        if (r_rd_vld) begin
            if ((rd_status == ST_ACTIVE) && key_match && !r_hit) begin
                r_hit_idx <= r_rd_idx;
            end
            if ((rd_status == ST_EMPTY) && !r_has_empty) begin
                r_empty_idx <= r_rd_idx;
            end
            if (((rd_status == ST_FULFILLED) || (rd_status == ST_RELEASED) ||
                 (rd_status == ST_VIOLATED)) && !r_has_term) begin
                r_term_idx <= r_rd_idx;
            end
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.commit))
        else $error("Result strobe without a commit step.");

    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_result.status != RES_OK)) |-> (r_result.slot_index == 4'd0))
        else $error("Failed item reports a nonzero slot.");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active <= CW'(TABLE_DEPTH)))
        else $error("Active count exceeds the table depth.");

endmodule

>>> rtl/commitment_table_engine_unit.sv
// ----------------------------------------------------------------------------
// Commitment table engine
// Table of commitments keyed by node and type, with open, close and
// capacity query commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item scans the
// whole table once through the single read port of the entry memory, one
// entry a cycle, then passes through a drain state for the last read and a
// commit state for the update, where the result is registered. Busy falls in
// the cycle the result is shown, so the next item can be taken at the edge
// that ends that cycle. o_result_strobe is high for exactly one cycle per
// result, o_result holds that result until the next update, and the
// receiver cannot stall it. The limit register may be written whenever the
// block is idle. The table is empty after reset without a clearing pass.
module commitment_table_engine_unit #(
    parameter int TABLE_DEPTH = cte_pkg::DEF_TABLE_DEPTH,
    parameter int NODE_COUNT  = cte_pkg::DEF_NODE_COUNT,
    parameter int TYPE_COUNT  = cte_pkg::DEF_TYPE_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cte_pkg::t_cmd    i_cmd,
    output logic             o_result_strobe,
    output cte_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [4:0]       i_cfg_data
);
    import cte_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    assign o_cfg_ready = 1'b1;

    cte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (ctrl_stat),
        .o_cmd   (ctrl_cmd),
        .o_busy  (busy)
    );

    cte_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NODE_COUNT  (NODE_COUNT),
        .TYPE_COUNT  (TYPE_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .o_stat     (ctrl_stat),
        .i_item     (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_result_strobe),
        .o_result   (o_result)
    );

endmodule
